// File: src/nnt_pkg.sv
package nnt_pkg;

    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] NUM_CITIES_RST = 6'd32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EMIT   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic start;
        logic wr_entry;
        logic emit;
        logic scan_init;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic res_last;
        logic scan_last;
    } t_status;

endpackage

// File: src/nearest_neighbour_tour_core.sv
// channel   | handshake         | payload
// ----------+-------------------+-----------------------------------------------
// input     | i_valid / o_stall | i_cmd, i_row, i_col, i_distance, i_start_city
// output    | o_valid / i_stall | o_city, o_position, o_last, o_error
// config    | i_cfg_we          | i_cfg_wdata (num_cities)
//
// A load transaction writes one distance entry. In a run transaction, each tour step
// scans one distance row through the single read port of the distance RAM, one
// entry per cycle, followed by drain and commit states. A bad start city ends the
// run with one error result. Reset is synchronous, active low; the distance
// RAM is not cleared. Output stall holds the result register and the tour.
module nearest_neighbour_tour_core #(
    parameter int MAX_CITIES = 32,
    parameter int DIST_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nnt_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_cmd,
    input  logic [4:0]                i_row,
    input  logic [4:0]                i_col,
    input  logic [15:0]               i_distance,
    input  logic [4:0]                i_start_city,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [4:0]                o_city,
    output logic [4:0]                o_position,
    output logic                      o_last,
    output logic                      o_error
);

    nnt_pkg::t_cmd    cmd;
    nnt_pkg::t_status status;

    nnt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nnt_dpath #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_distance   (i_distance),
        .i_start_city (i_start_city),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_city       (o_city),
        .o_position   (o_position),
        .o_last       (o_last),
        .o_error      (o_error)
    );

endmodule

// File: src/nnt_ram.sv
module nnt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/nnt_ctrl.sv
module nnt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_cmd,
    output logic            o_stall,
    input  nnt_pkg::t_status i_status,
    output nnt_pkg::t_cmd   o_cmd
);

    nnt_pkg::t_state r_state;
    nnt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            nnt_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == nnt_pkg::CMD_RUN) begin
                        o_cmd.start = 1'b1;
                        n_state     = nnt_pkg::S_EMIT;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            nnt_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.res_last) begin
                        n_state = nnt_pkg::S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = nnt_pkg::S_SCAN;
                    end
                end
            end
            nnt_pkg::S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = nnt_pkg::S_DRAIN;
                end
            end
            nnt_pkg::S_DRAIN: begin
                n_state = nnt_pkg::S_COMMIT;
            end
            nnt_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = nnt_pkg::S_EMIT;
            end
            default: begin
                n_state = nnt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != nnt_pkg::S_IDLE);

endmodule

// File: src/nnt_dpath.sv
module nnt_dpath #(
    parameter int MAX_CITIES = 32,
    parameter int DIST_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nnt_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [4:0]                i_row,
    input  logic [4:0]                i_col,
    input  logic [15:0]               i_distance,
    input  logic [4:0]                i_start_city,
    input  nnt_pkg::t_cmd             i_cmd,
    output nnt_pkg::t_status          o_status,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [4:0]                o_city,
    output logic [4:0]                o_position,
    output logic                      o_last,
    output logic                      o_error
);

    localparam int CW   = $clog2(MAX_CITIES);
    localparam int NW   = $clog2(MAX_CITIES + 1);
    localparam int CMPW = (NW > nnt_pkg::CFG_W) ? NW : nnt_pkg::CFG_W;
    localparam int DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int AW   = $clog2(DEPTH);

    logic [nnt_pkg::CFG_W-1:0] r_num_cities;
    logic [CMPW-1:0]           n_eff;
    logic [CMPW-1:0]           raw_n;

    logic [MAX_CITIES-1:0] r_visited;
    logic [CW-1:0]         r_cur;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_j;
    logic                  r_rd_valid;
    logic [CW-1:0]         r_rd_j;
    logic                  r_found;
    logic [CW-1:0]         r_best;
    logic [DIST_WIDTH-1:0] r_best_d;

    logic [CW-1:0] r_res_city;
    logic [CW-1:0] r_res_pos;
    logic          r_res_last;
    logic          r_res_err;

    logic          r_out_valid;
    logic [4:0]    r_out_city;
    logic [4:0]    r_out_pos;
    logic          r_out_last;
    logic          r_out_err;

    logic                  wr_en;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [DIST_WIDTH-1:0] rdata;
    logic                  start_bad;
    logic                  take;
    logic [CMPW-1:0]       next_pos;

    assign raw_n = CMPW'(r_num_cities);

    always_comb begin
        if (raw_n == '0) begin
            n_eff = CMPW'(1);
        end else if (raw_n > CMPW'(MAX_CITIES)) begin
            n_eff = CMPW'(MAX_CITIES);
        end else begin
            n_eff = raw_n;
        end
    end

    assign wr_en = i_cmd.wr_entry && (int'(i_row) < MAX_CITIES) && (int'(i_col) < MAX_CITIES);
    assign waddr = AW'(int'(i_row) * MAX_CITIES + int'(i_col));
    assign raddr = AW'(int'(r_cur) * MAX_CITIES + int'(r_j));

    nnt_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (DIST_WIDTH'(i_distance)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign start_bad = (CMPW'(i_start_city) >= n_eff);
    assign take      = r_rd_valid && !r_visited[r_rd_j] && (!r_found || (rdata < r_best_d));
    assign next_pos  = CMPW'(r_pos) + CMPW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cities <= nnt_pkg::NUM_CITIES_RST;
            r_visited    <= '0;
            r_cur        <= '0;
            r_pos        <= '0;
            r_j          <= '0;
            r_rd_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_cities <= i_cfg_wdata;
            end

            if (i_cmd.start && !start_bad) begin
                r_visited <= MAX_CITIES'(1) << CW'(i_start_city);
                r_cur     <= CW'(i_start_city);
                r_pos     <= '0;
            end else if (i_cmd.commit) begin
                r_visited <= r_visited | (MAX_CITIES'(1) << r_best);
                r_cur     <= r_best;
                r_pos     <= CW'(next_pos);
            end

            if (i_cmd.scan_init) begin
                r_j     <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_j <= r_j + CW'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            r_rd_valid <= i_cmd.issue;

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_j <= r_j;
        end
        if (take) begin
            r_best   <= r_rd_j;
            r_best_d <= rdata;
        end
        if (i_cmd.start) begin
            r_res_city <= start_bad ? '0 : CW'(i_start_city);
            r_res_pos  <= '0;
            r_res_last <= start_bad || (n_eff == CMPW'(1));
            r_res_err  <= start_bad;
        end else if (i_cmd.commit) begin
            r_res_city <= r_best;
            r_res_pos  <= CW'(next_pos);
            r_res_last <= (next_pos == (n_eff - CMPW'(1)));
            r_res_err  <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_city <= 5'(r_res_city);
            r_out_pos  <= 5'(r_res_pos);
            r_out_last <= r_res_last;
            r_out_err  <= r_res_err;
        end
    end

    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_status.res_last  = r_res_last;
    assign o_status.scan_last = (CMPW'(r_j) == (n_eff - CMPW'(1)));

    assign o_valid    = r_out_valid;
    assign o_city     = r_out_city;
    assign o_position = r_out_pos;
    assign o_last     = r_out_last;
    assign o_error    = r_out_err;

endmodule

// File: src/nnt_checker.sv
module nnt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_cmd,
    input logic       o_valid,
    input logic       i_stall,
    input logic [4:0] o_city,
    input logic [4:0] o_position,
    input logic       o_last,
    input logic       o_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_city) && $stable(o_position)
            && $stable(o_last) && $stable(o_error))
        else $error("stalled output changed");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last && (o_city == 5'd0) && (o_position == 5'd0))
        else $error("error result malformed");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == nnt_pkg::CMD_RUN) |=> o_stall)
        else $error("run transaction did not start a tour");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_cmd == nnt_pkg::CMD_LOAD) |=> !o_stall)
        else $error("load transaction blocked input");

endmodule

bind nearest_neighbour_tour_core nnt_checker u_nnt_checker (.*);
